// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// SLIP frame decoder package
// Shared widths, codes and the queue entry type of the SLIP frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int ByteW     = 8;
	localparam int CfgIdxW   = 2;
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);

	localparam logic [ByteW-1:0] EndReset       = 8'd192;
	localparam logic [ByteW-1:0] EscReset       = 8'd219;
	localparam logic [ByteW-1:0] EscEndReset    = 8'd220;
	localparam logic [ByteW-1:0] EscEscReset    = 8'd221;

	typedef enum logic [1:0] {
		PH_OUTSIDE,
		PH_INSIDE,
		PH_ESCAPE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_START,
		ST_BAD_ESCAPE,
		ST_INCOMPLETE
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_END_CODE,
		CFG_ESCAPE_CODE,
		CFG_ESCAPED_END_CODE,
		CFG_ESCAPED_ESCAPE_CODE
	} cfg_reg_t;

	typedef struct packed {
		logic             emit;
		logic [ByteW-1:0] data;
		logic             has_status;
		status_t          status;
	} entry_t;

endpackage

// ===== rtl/core/sfd_stream_if.sv =====
// ----------------------------------------------------------------------------
// SLIP frame decoder stream interfaces
// Valid/ready channels for framed input bytes and decoded result items.
// ----------------------------------------------------------------------------
interface sfd_in_if;
	logic                    valid;
	logic                    ready;
	logic [sfd_pkg::ByteW-1:0] in_byte;
	logic                    end_of_buffer;

	modport source (output valid, output in_byte, output end_of_buffer, input ready);
	modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface sfd_out_if;
	logic                    valid;
	logic                    ready;
	logic [sfd_pkg::ByteW-1:0] out_byte;
	logic                    is_status;
	logic [1:0]              status;
	logic                    last_result;

	modport source (output valid, output out_byte, output is_status, output status,
		output last_result, input ready);
	modport sink (input valid, input out_byte, input is_status, input status,
		input last_result, output ready);
endinterface

// ===== rtl/core/slip_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// SLIP frame decoder
// Accepts one framed byte per cycle while the queue is not full; a result
// item passes through the queue and then the output register. A byte that
// yields both a data and a status item gives two output items; a four-entry
// queue between classifier and output register absorbs this.
// Reset clears the framing state and the queue and restores the default codes.
// ----------------------------------------------------------------------------
module slip_frame_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sfd_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [sfd_pkg::ByteW-1:0]   cfg_data,
	sfd_in_if.sink                      framed,
	sfd_out_if.source                   decoded
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	sfd_pkg::entry_t q_wr;
	sfd_pkg::entry_t q_rd;

	sfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.framed    (framed),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_wr)
	);

	sfd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.rd_entry (q_rd)
	);

	sfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.head    (q_rd),
		.pop     (q_pop),
		.decoded (decoded)
	);

endmodule

// ===== rtl/core/sfd_front.sv =====
// ----------------------------------------------------------------------------
// SLIP frame decoder front end
// Holds the code registers and the framing state, classifies each input
// item and pushes the decoded byte and final status into the queue.
// ----------------------------------------------------------------------------
module sfd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [sfd_pkg::ByteW-1:0]     cfg_data,
	sfd_in_if.sink                        framed,
	input  logic                          q_full,
	output logic                          q_push,
	output sfd_pkg::entry_t               q_entry
);

	logic [sfd_pkg::ByteW-1:0] end_q;
	logic [sfd_pkg::ByteW-1:0] esc_q;
	logic [sfd_pkg::ByteW-1:0] esc_end_q;
	logic [sfd_pkg::ByteW-1:0] esc_esc_q;
	sfd_pkg::phase_t           phase_q;
	sfd_pkg::phase_t           phase_n;
	sfd_pkg::status_t          error_q;
	sfd_pkg::status_t          error_n;
	sfd_pkg::status_t          status;
	logic                      accept;
	logic                      emit;
	logic [sfd_pkg::ByteW-1:0] data;
	logic [sfd_pkg::ByteW-1:0] b;

	assign framed.ready = !q_full;
	assign accept       = framed.valid && framed.ready;
	assign b            = framed.in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q     <= sfd_pkg::EndReset;
			esc_q     <= sfd_pkg::EscReset;
			esc_end_q <= sfd_pkg::EscEndReset;
			esc_esc_q <= sfd_pkg::EscEscReset;
		end else if (cfg_we) begin
			unique case (sfd_pkg::cfg_reg_t'(cfg_index))
				sfd_pkg::CFG_END_CODE:            end_q     <= cfg_data;
				sfd_pkg::CFG_ESCAPE_CODE:         esc_q     <= cfg_data;
				sfd_pkg::CFG_ESCAPED_END_CODE:    esc_end_q <= cfg_data;
				sfd_pkg::CFG_ESCAPED_ESCAPE_CODE: esc_esc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_n = phase_q;
		error_n = error_q;
		emit    = 1'b0;
		data    = b;
		if (error_q == sfd_pkg::ST_OK) begin
			unique case (phase_q)
				sfd_pkg::PH_INSIDE: begin
					if (b == end_q) begin
						phase_n = sfd_pkg::PH_OUTSIDE;
					end else if (b == esc_q) begin
						phase_n = sfd_pkg::PH_ESCAPE;
					end else begin
						emit = 1'b1;
					end
				end
				sfd_pkg::PH_ESCAPE: begin
					if (b == esc_end_q) begin
						emit    = 1'b1;
						data    = end_q;
						phase_n = sfd_pkg::PH_INSIDE;
					end else if (b == esc_esc_q) begin
						emit    = 1'b1;
						data    = esc_q;
						phase_n = sfd_pkg::PH_INSIDE;
					end else begin
						error_n = sfd_pkg::ST_BAD_ESCAPE;
					end
				end
				default: begin
					if (b == end_q) begin
						phase_n = sfd_pkg::PH_INSIDE;
					end else begin
						error_n = sfd_pkg::ST_BAD_START;
					end
				end
			endcase
		end

		if (error_n != sfd_pkg::ST_OK) begin
			status = error_n;
		end else if (phase_n == sfd_pkg::PH_INSIDE || phase_n == sfd_pkg::PH_ESCAPE) begin
			status = sfd_pkg::ST_INCOMPLETE;
		end else begin
			status = sfd_pkg::ST_OK;
		end

		q_entry.emit       = emit;
		q_entry.data       = data;
		q_entry.has_status = framed.end_of_buffer;
		q_entry.status     = status;
		q_push             = accept && (emit || framed.end_of_buffer);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_OUTSIDE;
			error_q <= sfd_pkg::ST_OK;
		end else if (accept) begin
			if (framed.end_of_buffer) begin
				phase_q <= sfd_pkg::PH_OUTSIDE;
				error_q <= sfd_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				error_q <= error_n;
			end
		end
	end

endmodule

// ===== rtl/core/sfd_fifo.sv =====
// ----------------------------------------------------------------------------
// SLIP frame decoder queue
// Short register queue that decouples the front end from the result stage.
// ----------------------------------------------------------------------------
module sfd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfd_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output sfd_pkg::entry_t rd_entry
);

	localparam logic [sfd_pkg::FifoPtrW:0] FullCount = (sfd_pkg::FifoPtrW + 1)'(sfd_pkg::FifoDepth);

	sfd_pkg::entry_t               mem_q [sfd_pkg::FifoDepth];
	logic [sfd_pkg::FifoPtrW-1:0]  wr_ptr_q;
	logic [sfd_pkg::FifoPtrW-1:0]  rd_ptr_q;
	logic [sfd_pkg::FifoPtrW:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full     = (count_q == FullCount);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/sfd_back.sv =====
// ----------------------------------------------------------------------------
// SLIP frame decoder result stage
// Expands each queue entry into a data item, a status item or both, and
// holds them in an output register until the sink takes them.
// ----------------------------------------------------------------------------
module sfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  sfd_pkg::entry_t head,
	output logic            pop,
	sfd_out_if.source       decoded
);

	logic                      valid_q;
	logic [sfd_pkg::ByteW-1:0] byte_q;
	logic                      is_status_q;
	sfd_pkg::status_t          status_q;
	logic                      last_q;
	logic                      data_done_q;
	logic                      data_done_n;
	logic                      load;
	logic                      produce;
	logic [sfd_pkg::ByteW-1:0] res_byte;
	logic                      res_is_status;
	sfd_pkg::status_t          res_status;
	logic                      res_last;

	assign load = !valid_q || decoded.ready;

	always_comb begin
		pop           = 1'b0;
		produce       = 1'b0;
		data_done_n   = data_done_q;
		res_byte      = '0;
		res_is_status = 1'b0;
		res_status    = sfd_pkg::ST_OK;
		res_last      = 1'b0;
		if (load && !empty) begin
			produce = 1'b1;
			if (head.emit && !data_done_q) begin
				res_byte = head.data;
				res_last = !head.has_status;
				if (head.has_status) begin
					data_done_n = 1'b1;
				end else begin
					pop = 1'b1;
				end
			end else begin
				res_is_status = 1'b1;
				res_status    = head.status;
				res_last      = 1'b1;
				pop           = 1'b1;
				data_done_n   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			data_done_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= produce;
			end
			data_done_q <= data_done_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load && produce) begin
			byte_q      <= res_byte;
			is_status_q <= res_is_status;
			status_q    <= res_status;
			last_q      <= res_last;
		end
	end

	assign decoded.valid       = valid_q;
	assign decoded.out_byte    = byte_q;
	assign decoded.is_status   = is_status_q;
	assign decoded.status      = status_q;
	assign decoded.last_result = last_q;

endmodule

// ===== rtl/core/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// SLIP frame decoder checker
// Watches the result channel of the decoder for malformed result items.
// ----------------------------------------------------------------------------
module sfd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      valid,
	input logic                      ready,
	input logic [sfd_pkg::ByteW-1:0] out_byte,
	input logic                      is_status,
	input logic [1:0]                status,
	input logic                      last_result
);

	a_status_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_status |-> last_result)
		else $error("Status item without last_result.");

	a_status_byte_zero : assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_status |-> out_byte == '0)
		else $error("Status item carries a nonzero byte.");

	a_data_status_ok : assert property (@(posedge clk) disable iff (!arst_n)
		valid && !is_status |-> status == sfd_pkg::ST_OK)
		else $error("Data item carries a nonzero status.");

	a_stall_holds : assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(is_status)
			&& $stable(status) && $stable(last_result))
		else $error("Stalled result item changed.");

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (decoded.valid),
	.ready       (decoded.ready),
	.out_byte    (decoded.out_byte),
	.is_status   (decoded.is_status),
	.status      (decoded.status),
	.last_result (decoded.last_result)
);
